### rtl/core/cpu_process_scheduler_unit_assert.svh
// assertion macros for the process scheduler
`ifndef CPU_PROCESS_SCHEDULER_UNIT_ASSERT_SVH
`define CPU_PROCESS_SCHEDULER_UNIT_ASSERT_SVH
// check that a condition implies a consequence on the same edge
`define CPS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");
// check that a condition implies a consequence on the next edge
`define CPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");
`endif

### rtl/core/cps_pkg.sv
// shared types and constants of the process scheduler
package cps_pkg;
    localparam int QueueDepth = 32;
    localparam int IdxW = $clog2(QueueDepth);
    localparam int LenW = 6;
    localparam logic [1:0] MODE_RR = 2'd0;
    localparam logic [1:0] MODE_STATIC = 2'd1;
    localparam logic [1:0] MODE_DYNAMIC = 2'd2;
    localparam logic [0:0] CFG_POLICY = 1'b0;
    localparam logic [0:0] CFG_QUANTUM = 1'b1;
    typedef struct packed {
        logic [7:0] id;
        logic [7:0] rem;
        logic [3:0] prio;
    } proc_rec_t;
endpackage

### rtl/core/cpu_process_scheduler_unit.sv
// Process scheduler with a ready queue held in a synchronous memory and one
// running slot. One request is in flight at a time, and its result waits in
// output registers until it is taken. A tick in round robin pops the head,
// which shifts the queue one entry at a time through the memory. A tick in
// a priority mode first runs the exchange sort over all pairs, with an extra
// write step when a pair swaps, and then pops the head for a dispatch or a
// preemption.
module cpu_process_scheduler_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] new_id,
    input  logic [7:0] new_burst,
    input  logic [3:0] new_priority,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       cpu_busy,
    output logic [7:0] cpu_id,
    output logic [7:0] time_left,
    output logic [3:0] prio_now,
    output logic       dispatched,
    output logic       preempted,
    output logic       finished,
    output logic       rotated,
    output logic       dropped,
    output logic [5:0] queue_len,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE, S_ARR, S_TICK, S_SRT_A, S_SRT_B, S_SRT_WA, S_SRT_CMP,
        S_PRE, S_POP_R, S_POP_W, S_POP_DONE, S_EXEC, S_PUSH_RUN, S_OUT
    } state_t;

    localparam int IW = cps_pkg::IdxW;
    localparam int LW = cps_pkg::LenW;

    // ready queue memory
    cps_pkg::proc_rec_t mem [cps_pkg::QueueDepth];
    cps_pkg::proc_rec_t rd_reg;
    logic [IW-1:0]      raddr;
    logic               wen;
    logic [IW-1:0]      waddr;
    cps_pkg::proc_rec_t wdata;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    state_t             state_reg;
    logic [1:0]         mode_reg;
    logic [3:0]         quant_reg;
    logic [LW-1:0]      len_reg;
    cps_pkg::proc_rec_t run_reg;
    logic               run_v_reg;
    logic [3:0]         slice_reg;
    cps_pkg::proc_rec_t ra_reg;
    cps_pkg::proc_rec_t arr_reg;
    logic [LW-1:0]      ia_reg;
    logic [LW-1:0]      ib_reg;
    logic [2:0]         ret_reg;
    logic               disp_reg, pre_reg, fin_reg, rot_reg, drop_reg, busy_reg;
    cps_pkg::proc_rec_t shown_reg;
    logic [LW-1:0]      pidx_reg;

    // return points after a pop
    localparam logic [2:0] RET_DISP = 3'd0;
    localparam logic [2:0] RET_PRE = 3'd1;
    localparam logic [2:0] RET_RR = 3'd2;
    localparam logic [2:0] RET_LOST = 3'd3;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign out_valid = (state_reg == S_OUT);
    assign cpu_busy   = busy_reg;
    assign cpu_id     = shown_reg.id;
    assign time_left  = shown_reg.rem;
    assign prio_now   = shown_reg.prio;
    assign dispatched = disp_reg;
    assign preempted  = pre_reg;
    assign finished   = fin_reg;
    assign rotated    = rot_reg;
    assign dropped    = drop_reg;
    assign queue_len  = len_reg;

    logic               full;
    logic               is_prio;
    cps_pkg::proc_rec_t ex;
    logic [3:0]         slice_inc;
    assign full    = (len_reg >= LW'(cps_pkg::QueueDepth));
    assign is_prio = (mode_reg == cps_pkg::MODE_STATIC) || (mode_reg == cps_pkg::MODE_DYNAMIC);

    // address and write selection
    always_comb
    begin
        raddr = ia_reg[IW-1:0];
        wen   = 1'b0;
        waddr = ia_reg[IW-1:0];
        wdata = ra_reg;
        case (state_reg)
            S_ARR:
            begin
                wen   = !full;
                waddr = len_reg[IW-1:0];
                wdata = arr_reg;
            end
            S_SRT_A:   raddr = ib_reg[IW-1:0];
            S_SRT_CMP:
            begin
                wen   = (ra_reg.prio < rd_reg.prio);
                waddr = ia_reg[IW-1:0];
                wdata = rd_reg;
            end
            S_SRT_WA:
            begin
                wen   = 1'b1;
                waddr = ib_reg[IW-1:0];
                wdata = rd_reg;
            end
            S_POP_R:   raddr = pidx_reg[IW-1:0] + IW'(1);
            S_POP_W:
            begin
                wen   = 1'b1;
                waddr = pidx_reg[IW-1:0];
                wdata = rd_reg;
            end
            S_PUSH_RUN:
            begin
                wen   = !full;
                waddr = len_reg[IW-1:0];
                wdata = ra_reg;
            end
            default:   raddr = ia_reg[IW-1:0];
        endcase
    end

    // executed record after one tick
    always_comb
    begin
        ex = run_reg;
        if (ex.rem != 8'd0)
        begin
            ex.rem = ex.rem - 8'd1;
        end
        if (mode_reg == cps_pkg::MODE_DYNAMIC && ex.prio != 4'd0)
        begin
            ex.prio = ex.prio - 4'd1;
        end
        slice_inc = (slice_reg < 4'd15) ? slice_reg + 4'd1 : slice_reg;
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= cps_pkg::MODE_DYNAMIC;
            quant_reg <= 4'd2;
            len_reg   <= '0;
            run_reg   <= '0;
            run_v_reg <= 1'b0;
            slice_reg <= '0;
            ra_reg    <= '0;
            arr_reg   <= '0;
            ia_reg    <= '0;
            ib_reg    <= '0;
            pidx_reg  <= '0;
            ret_reg   <= RET_DISP;
            disp_reg  <= 1'b0;
            pre_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            rot_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            shown_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                    begin
                        if (cfg_index == cps_pkg::CFG_POLICY)
                        begin
                            mode_reg <= cfg_data[1:0];
                        end
                        else
                        begin
                            quant_reg <= cfg_data;
                        end
                    end
                    if (in_valid)
                    begin
                        arr_reg   <= '{new_id, new_burst, new_priority};
                        disp_reg  <= 1'b0;
                        pre_reg   <= 1'b0;
                        fin_reg   <= 1'b0;
                        rot_reg   <= 1'b0;
                        drop_reg  <= 1'b0;
                        busy_reg  <= 1'b0;
                        shown_reg <= '0;
                        ia_reg    <= '0;
                        ib_reg    <= LW'(1);
                        state_reg <= func ? S_TICK : S_ARR;
                    end
                end
                S_ARR:
                begin
                    if (full)
                    begin
                        drop_reg <= 1'b1;
                    end
                    else
                    begin
                        len_reg <= len_reg + LW'(1);
                    end
                    state_reg <= S_OUT;
                end
                S_TICK:
                begin
                    if (mode_reg == cps_pkg::MODE_RR)
                    begin
                        if (!run_v_reg && len_reg != '0)
                        begin
                            // head read is issued here, taken on the first pop step
                            run_v_reg <= 1'b1;
                            slice_reg <= '0;
                            disp_reg  <= 1'b1;
                            pidx_reg  <= '0;
                            ret_reg   <= RET_RR;
                            state_reg <= S_POP_R;
                        end
                        else
                        begin
                            state_reg <= S_EXEC;
                        end
                    end
                    else if (is_prio)
                    begin
                        // outer sort index at 0 reads entry a
                        state_reg <= (len_reg > LW'(1)) ? S_SRT_B : S_PRE;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                // sort: entry a read issued here via raddr=ia
                S_SRT_B:   state_reg <= S_SRT_A;
                S_SRT_A:
                begin
                    ra_reg    <= rd_reg;
                    state_reg <= S_SRT_CMP;
                end
                S_SRT_CMP:
                begin
                    if (ra_reg.prio < rd_reg.prio)
                    begin
                        state_reg <= S_SRT_WA;
                    end
                    else if (ib_reg + LW'(1) < len_reg)
                    begin
                        ib_reg    <= ib_reg + LW'(1);
                        state_reg <= S_SRT_A;
                    end
                    else if (ia_reg + LW'(2) < len_reg)
                    begin
                        ia_reg    <= ia_reg + LW'(1);
                        ib_reg    <= ia_reg + LW'(2);
                        state_reg <= S_SRT_B;
                    end
                    else
                    begin
                        ia_reg    <= '0;
                        state_reg <= S_PRE;
                    end
                    if (ra_reg.prio < rd_reg.prio)
                    begin
                        ra_reg <= rd_reg;
                    end
                end
                S_SRT_WA:
                begin
                    // old entry a, read back during the compare, goes to entry b
                    if (ib_reg + LW'(1) < len_reg)
                    begin
                        ib_reg    <= ib_reg + LW'(1);
                        state_reg <= S_SRT_B;
                    end
                    else if (ia_reg + LW'(2) < len_reg)
                    begin
                        ia_reg    <= ia_reg + LW'(1);
                        ib_reg    <= ia_reg + LW'(2);
                        state_reg <= S_SRT_B;
                    end
                    else
                    begin
                        ia_reg    <= '0;
                        state_reg <= S_PRE;
                    end
                end
                S_PRE:
                begin
                    // read of head issued here (raddr = ia = 0)
                    state_reg <= S_POP_DONE;
                    ret_reg   <= RET_DISP;
                end
                S_POP_DONE:
                begin
                    // rd_reg holds the sorted head
                    if (ret_reg == RET_DISP && !run_v_reg && len_reg != '0)
                    begin
                        run_reg   <= rd_reg;
                        run_v_reg <= 1'b1;
                        disp_reg  <= 1'b1;
                        if (mode_reg == cps_pkg::MODE_DYNAMIC)
                        begin
                            slice_reg <= '0;
                        end
                        pidx_reg  <= '0;
                        ret_reg   <= RET_PRE;
                        state_reg <= S_POP_R;
                    end
                    else if (run_v_reg && len_reg != '0 && run_reg.prio < rd_reg.prio
                             && ret_reg != RET_RR)
                    begin
                        pre_reg   <= 1'b1;
                        disp_reg  <= 1'b1;
                        ra_reg    <= run_reg;
                        run_reg   <= rd_reg;
                        pidx_reg  <= '0;
                        // a full queue has no room for the displaced process
                        if (full)
                        begin
                            drop_reg <= 1'b1;
                            ret_reg  <= RET_LOST;
                        end
                        else
                        begin
                            ret_reg  <= RET_RR;
                        end
                        state_reg <= S_POP_R;
                    end
                    else
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_POP_R:
                begin
                    // round robin dispatch takes the head read during the tick step
                    if (ret_reg == RET_RR && mode_reg == cps_pkg::MODE_RR && pidx_reg == '0)
                    begin
                        run_reg <= rd_reg;
                    end
                    if (pidx_reg + LW'(1) < len_reg)
                    begin
                        state_reg <= S_POP_W;
                    end
                    else
                    begin
                        len_reg <= len_reg - LW'(1);
                        if (ret_reg == RET_RR && mode_reg == cps_pkg::MODE_RR)
                        begin
                            state_reg <= S_EXEC;
                        end
                        else if (ret_reg == RET_PRE)
                        begin
                            ia_reg    <= '0;
                            state_reg <= S_PRE;
                        end
                        else if (ret_reg == RET_LOST)
                        begin
                            state_reg <= S_EXEC;
                        end
                        else
                        begin
                            state_reg <= S_PUSH_RUN;
                        end
                    end
                end
                S_POP_W:
                begin
                    pidx_reg  <= pidx_reg + LW'(1);
                    state_reg <= S_POP_R;
                end
                S_PUSH_RUN:
                begin
                    if (full)
                    begin
                        drop_reg <= 1'b1;
                    end
                    else
                    begin
                        len_reg <= len_reg + LW'(1);
                    end
                    state_reg <= (mode_reg == cps_pkg::MODE_RR) ? S_OUT : S_EXEC;
                end
                S_EXEC:
                begin
                    if (run_v_reg)
                    begin
                        busy_reg  <= 1'b1;
                        shown_reg <= ex;
                        run_reg   <= ex;
                        state_reg <= S_OUT;
                        if (mode_reg == cps_pkg::MODE_RR)
                        begin
                            if (ex.rem == 8'd0)
                            begin
                                fin_reg   <= 1'b1;
                                run_v_reg <= 1'b0;
                                slice_reg <= '0;
                            end
                            else if (slice_inc >= quant_reg)
                            begin
                                rot_reg   <= 1'b1;
                                run_v_reg <= 1'b0;
                                slice_reg <= '0;
                                ra_reg    <= ex;
                                state_reg <= S_PUSH_RUN;
                            end
                            else
                            begin
                                slice_reg <= slice_inc;
                            end
                        end
                        else if (ex.rem == 8'd0)
                        begin
                            fin_reg   <= 1'b1;
                            run_v_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    `include "cpu_process_scheduler_unit_assert.svh"

    `CPS_ASSERT_IMPL(a_len_bound, 1'b1, len_reg <= LW'(cps_pkg::QueueDepth))
    `CPS_ASSERT_IMPL(a_out_idle, out_valid && !cpu_busy, cpu_id == 8'd0 && time_left == 8'd0)
    `CPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(queue_len))
    `CPS_ASSERT_IMPL(a_fin_busy, out_valid && finished, cpu_busy && time_left == 8'd0)
endmodule

### tb/cpu_process_scheduler_unit_tb.sv
// self-checking testbench of the process scheduler with its own scheduling predictor
module cpu_process_scheduler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic       busy;
        logic [7:0] id;
        logic [7:0] left;
        logic [3:0] prio;
        logic       disp;
        logic       pre;
        logic       fin;
        logic       rot;
        logic       drop;
        logic [5:0] qlen;
    } sched_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       func;
    logic [7:0] new_id;
    logic [7:0] new_burst;
    logic [3:0] new_priority;
    logic       out_valid;
    logic       out_ready;
    logic       cpu_busy;
    logic [7:0] cpu_id;
    logic [7:0] time_left;
    logic [3:0] prio_now;
    logic       dispatched;
    logic       preempted;
    logic       finished;
    logic       rotated;
    logic       dropped;
    logic [5:0] queue_len;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [3:0] cfg_data;

    // predictor state
    cps_pkg::proc_rec_t ready_q[$];
    cps_pkg::proc_rec_t running;
    logic               running_valid;
    logic [3:0]         slice_cnt;
    logic [1:0]         policy;
    logic [3:0]         quantum;
    sched_result_t      expected_results[$];

    int fail_cnt;
    int mismatch_cnt;
    int burst_left;
    int hold_cycles;

    cpu_process_scheduler_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .new_id       (new_id),
        .new_burst    (new_burst),
        .new_priority (new_priority),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cpu_busy     (cpu_busy),
        .cpu_id       (cpu_id),
        .time_left    (time_left),
        .prio_now     (prio_now),
        .dispatched   (dispatched),
        .preempted    (preempted),
        .finished     (finished),
        .rotated      (rotated),
        .dropped      (dropped),
        .queue_len    (queue_len),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #60_000_000;
        $display("cpu_process_scheduler_unit regression: fail");
        $finish;
    end

    // append to the ready queue, false when full
    function automatic logic queue_append(cps_pkg::proc_rec_t r);
        if (ready_q.size() >= cps_pkg::QueueDepth)
            return 1'b0;
        ready_q.push_back(r);
        return 1'b1;
    endfunction

    // descending exchange sort on priority
    function automatic void priority_sort();
        cps_pkg::proc_rec_t t;
        for (int a = 0; a < ready_q.size(); a++)
        begin
            for (int b = a + 1; b < ready_q.size(); b++)
            begin
                if (ready_q[a].prio < ready_q[b].prio)
                begin
                    t = ready_q[a];
                    ready_q[a] = ready_q[b];
                    ready_q[b] = t;
                end
            end
        end
    endfunction

    // one scheduling step of the predictor
    function automatic sched_result_t schedule_step(logic f, logic [7:0] id,
                                                    logic [7:0] burst, logic [3:0] pr);
        sched_result_t      res;
        cps_pkg::proc_rec_t rec;
        res = '0;
        if (f == FUNC_ARRIVE)
        begin
            rec.id = id;
            rec.rem = burst;
            rec.prio = pr;
            if (!queue_append(rec))
                res.drop = 1'b1;
        end
        else if (policy == cps_pkg::MODE_RR)
        begin
            if (!running_valid && ready_q.size() > 0)
            begin
                running = ready_q.pop_front();
                running_valid = 1'b1;
                slice_cnt = '0;
                res.disp = 1'b1;
            end
            if (running_valid)
            begin
                res.busy = 1'b1;
                if (running.rem > 0)
                    running.rem--;
                if (slice_cnt < 4'd15)
                    slice_cnt++;
                res.id = running.id;
                res.left = running.rem;
                res.prio = running.prio;
                if (running.rem == 0)
                begin
                    res.fin = 1'b1;
                    running_valid = 1'b0;
                    slice_cnt = '0;
                end
                else if (slice_cnt >= quantum)
                begin
                    res.rot = 1'b1;
                    if (!queue_append(running))
                        res.drop = 1'b1;
                    running_valid = 1'b0;
                    slice_cnt = '0;
                end
            end
        end
        else if (policy == cps_pkg::MODE_STATIC || policy == cps_pkg::MODE_DYNAMIC)
        begin
            priority_sort();
            if (!running_valid && ready_q.size() > 0)
            begin
                running = ready_q.pop_front();
                running_valid = 1'b1;
                if (policy == cps_pkg::MODE_DYNAMIC)
                    slice_cnt = '0;
                res.disp = 1'b1;
            end
            if (running_valid && ready_q.size() > 0 && running.prio < ready_q[0].prio)
            begin
                res.pre = 1'b1;
                res.disp = 1'b1;
                if (!queue_append(running))
                    res.drop = 1'b1;
                running = ready_q.pop_front();
            end
            if (running_valid)
            begin
                res.busy = 1'b1;
                if (running.rem > 0)
                    running.rem--;
                if (policy == cps_pkg::MODE_DYNAMIC && running.prio > 0)
                    running.prio--;
                res.id = running.id;
                res.left = running.rem;
                res.prio = running.prio;
                if (running.rem == 0)
                begin
                    res.fin = 1'b1;
                    running_valid = 1'b0;
                end
            end
        end
        res.qlen = 6'(ready_q.size());
        return res;
    endfunction

    // send one request, bursts with random gaps in between
    task automatic send_item(logic f, logic [7:0] id, logic [7:0] burst, logic [3:0] pr);
        in_valid <= 1'b1;
        func <= f;
        new_id <= id;
        new_burst <= burst;
        new_priority <= pr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(schedule_step(f, id, burst, pr));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, 8'($urandom), 8'($urandom), 4'($urandom));
    endtask

    // drop valid and wait for all results to come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(logic idx, logic [3:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == cps_pkg::CFG_POLICY)
            policy = data[1:0];
        else
            quantum = data;
    endtask

    // random request steering the queue toward a target length
    task automatic random_item(int target);
        logic [7:0] burst;
        int         arrive_pct;
        arrive_pct = (ready_q.size() < target) ? 80 : 25;
        if ($urandom_range(0, 99) < 70)
            burst = 8'($urandom_range(0, 6));
        else
            burst = 8'($urandom);
        if ($urandom_range(0, 99) < arrive_pct)
            send_item(FUNC_ARRIVE, 8'($urandom), burst, 4'($urandom));
        else
            send_tick();
    endtask

    // receiver stall pattern with an optional long hold-off
    initial
    begin
        int style;
        int style_left;
        out_ready = 1'b0;
        style = 0;
        style_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (style_left == 0)
            begin
                style = $urandom_range(0, 2);
                style_left = $urandom_range(50, 400);
            end
            style_left--;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (style == 0)
                out_ready <= 1'b1;
            else if (style == 1)
                out_ready <= ($urandom_range(0, 1) == 1);
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    initial
    begin
        sched_result_t act;
        sched_result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                act = '{cpu_busy, cpu_id, time_left, prio_now, dispatched, preempted,
                        finished, rotated, dropped, queue_len};
                if (expected_results.size() == 0)
                begin
                    fail_cnt++;
                    $display("unexpected result %p", act);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (act.busy !== exp_r.busy || act.id !== exp_r.id
                        || act.left !== exp_r.left || act.prio !== exp_r.prio
                        || act.disp !== exp_r.disp || act.pre !== exp_r.pre
                        || act.fin !== exp_r.fin || act.rot !== exp_r.rot
                        || act.drop !== exp_r.drop || act.qlen !== exp_r.qlen)
                    begin
                        fail_cnt++;
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display("mismatch at %0t: expected %p actual %p",
                                     $realtime, exp_r, act);
                    end
                end
            end
        end
    end

    // extremes, zero burst, rotation and finishing in round robin
    task automatic test_round_robin();
        write_reg(cps_pkg::CFG_POLICY, {2'b00, cps_pkg::MODE_RR});
        write_reg(cps_pkg::CFG_QUANTUM, 4'd2);
        send_item(FUNC_ARRIVE, 8'h00, 8'h00, 4'h0);
        send_item(FUNC_ARRIVE, 8'hFF, 8'hFF, 4'hF);
        send_item(FUNC_ARRIVE, 8'h5A, 8'h03, 4'h7);
        repeat (5)
            send_tick();
        write_reg(cps_pkg::CFG_QUANTUM, 4'd0);
        repeat (3)
            send_tick();
    endtask

    // unused policy idles the cpu while arrivals still append
    task automatic test_unused_policy();
        write_reg(cps_pkg::CFG_POLICY, {2'b11, MODE_UNUSED});
        send_tick();
        send_item(FUNC_ARRIVE, 8'hA5, 8'h01, 4'h3);
        send_tick();
    endtask

    // sorting, preemption and ageing in the priority modes
    task automatic test_priority_modes();
        write_reg(cps_pkg::CFG_POLICY, {2'b00, cps_pkg::MODE_STATIC});
        send_item(FUNC_ARRIVE, 8'h11, 8'h04, 4'h2);
        send_tick();
        send_item(FUNC_ARRIVE, 8'h22, 8'h02, 4'hC);
        send_tick();
        write_reg(cps_pkg::CFG_POLICY, {2'b00, cps_pkg::MODE_DYNAMIC});
        send_item(FUNC_ARRIVE, 8'h33, 8'h05, 4'h1);
        repeat (4)
            send_tick();
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        write_reg(cps_pkg::CFG_POLICY, {2'b00, cps_pkg::MODE_RR});
        hold_cycles = 400;
        repeat (40)
            random_item(4);
    endtask

    // random phases over policies, quanta and queue fill levels
    task automatic test_random();
        int target;
        int count;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(cps_pkg::CFG_POLICY, {2'b00, cps_pkg::MODE_RR});
                    write_reg(cps_pkg::CFG_QUANTUM, 4'd1);
                end
                1: write_reg(cps_pkg::CFG_QUANTUM, 4'd15);
                2: write_reg(cps_pkg::CFG_QUANTUM, 4'd0);
                3: write_reg(cps_pkg::CFG_POLICY, {2'b01, cps_pkg::MODE_STATIC});
                4: write_reg(cps_pkg::CFG_POLICY, {2'b10, cps_pkg::MODE_DYNAMIC});
                5: write_reg(cps_pkg::CFG_POLICY, {2'b00, MODE_UNUSED});
                default:
                begin
                    write_reg(cps_pkg::CFG_POLICY, 4'($urandom_range(0, 2)));
                    write_reg(cps_pkg::CFG_QUANTUM, 4'($urandom_range(0, 15)));
                end
            endcase
            count = (ph >= 7) ? 90 : 230;
            target = 3;
            for (int n = 0; n < count; n++)
            begin
                if (n % 20 == 0)
                    target = (ph >= 7) ? cps_pkg::QueueDepth + 2
                                       : int'($urandom_range(0, 6));
                random_item(target);
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_ARRIVE;
        new_id = '0;
        new_burst = '0;
        new_priority = '0;
        cfg_valid = 1'b0;
        cfg_index = cps_pkg::CFG_POLICY;
        cfg_data = '0;
        fail_cnt = 0;
        mismatch_cnt = 0;
        burst_left = 0;
        hold_cycles = 0;
        running = '0;
        running_valid = 1'b0;
        slice_cnt = '0;
        policy = cps_pkg::MODE_DYNAMIC;
        quantum = 4'd2;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_round_robin();
        test_unused_policy();
        test_priority_modes();
        test_backpressure();
        test_random();
        drain();
        repeat (50)
            @(posedge clk);
        fail_cnt += expected_results.size();
        if (fail_cnt == 0)
            $display("cpu_process_scheduler_unit regression: pass");
        else
            $display("cpu_process_scheduler_unit regression: fail");
        $finish;
    end
endmodule
